### hw/rtl/wfm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfm_pkg
// Shared types, constants and helpers of the wildcard file name matcher.
// ----------------------------------------------------------------------------
package wfm_pkg;

  localparam int PATTERN_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
  localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NAME = 1'b1;

  // One queued transfer, already classified by the front end.
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       term;
    logic       dot;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/wildcard_filename_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_filename_matcher
// DOS-style wildcard matcher: loads a pattern, then checks file names.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                              | Transfer
//  ---------+------------------------------------+---------------------------
//  input    | start, busy, in_operation,         | start high, busy low
//           | in_char_code                       |
//  result   | out_valid, out_match,              | out_valid high, one cycle
//           | out_pattern_overflow               |
//
// A pattern byte is written straight from the idle state; a plain name byte
// needs a store read, then the compare. A star in name mode walks the store
// one entry per cycle on the single read port up to the next dot or the
// pattern end, and one more compare follows when the name ends.
// Reset is synchronous and active low; it clears length and control state,
// not the store. The receiver cannot stall; busy is high only while the
// two-entry queue between the front and back ends is full.
//
module wildcard_filename_matcher (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_char_code,
  output logic            out_valid,
  output logic            out_match,
  output logic            out_pattern_overflow
);

  // Queue head from the front end and the pop that retires it.
  wfm_pkg::head_t head;
  logic           pop;

  // The front end takes transfers and tags terminators and dots.
  wfm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_char_code (in_char_code),
    .head         (head),
    .pop          (pop)
  );

  // The back end owns the pattern store and the matching sequencer.
  wfm_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_match            (out_match),
    .out_pattern_overflow (out_pattern_overflow)
  );

endmodule
`default_nettype wire

### hw/rtl/wfm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/wfm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfm_front
// Accepts command transfers, classifies the byte and queues them.
// ----------------------------------------------------------------------------
module wfm_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          in_operation,
  input  wire logic [7:0]    in_char_code,
  output wfm_pkg::head_t     head,
  input  wire logic          pop
);

  localparam int PW = $clog2(wfm_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(wfm_pkg::QUEUE_DEPTH + 1);

  wfm_pkg::item_t slot_r [wfm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push;
  wfm_pkg::item_t new_item;

  assign busy = (count_r == CW'(wfm_pkg::QUEUE_DEPTH));
  assign push = start && !busy;

  always_comb begin
    new_item.op   = in_operation;
    new_item.ch   = in_char_code;
    new_item.term = (in_char_code == wfm_pkg::CH_NUL);
    new_item.dot  = (in_char_code == wfm_pkg::CH_DOT);
  end

  assign head.valid = (count_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(wfm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/wfm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfm_back
// Pattern store and matching sequencer; emits one result per name end.
// ----------------------------------------------------------------------------
module wfm_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire wfm_pkg::head_t head,
  output logic               pop,
  output logic               out_valid,
  output logic               out_match,
  output logic               out_pattern_overflow
);

  localparam int AW = wfm_pkg::ADDR_W;
  localparam int LW = wfm_pkg::LEN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   pos_r, pos_nxt;
  logic            ext_r, ext_nxt;
  logic            skip_r, skip_nxt;
  logic            dec_r, dec_nxt;
  logic            dval_r, dval_nxt;
  logic            ovf_r, ovf_nxt;
  logic            closed_r, closed_nxt;
  wfm_pkg::item_t  cur_r, cur_nxt;
  logic            valid_nxt, match_nxt, povf_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;
  logic [LW-1:0]   len_eff;
  logic [7:0]      pc;
  logic            in_range;
  logic            finish;
  wfm_pkg::item_t  c;

  wfm_ram #(.WIDTH(8), .DEPTH(wfm_pkg::PATTERN_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (head.item.ch),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_range = (pos_r < len_r);
  assign pc       = in_range ? rdata : wfm_pkg::CH_NUL;
  assign len_eff  = closed_r ? '0 : len_r;
  assign c        = (state_r == ST_IDLE) ? head.item : cur_r;
  assign waddr    = len_eff[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    ext_nxt    = ext_r;
    skip_nxt   = skip_r;
    dec_nxt    = dec_r;
    dval_nxt   = dval_r;
    ovf_nxt    = ovf_r;
    closed_nxt = closed_r;
    cur_nxt    = cur_r;
    valid_nxt  = 1'b0;
    match_nxt  = out_match;
    povf_nxt   = out_pattern_overflow;
    pop        = 1'b0;
    we         = 1'b0;
    finish     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop     = 1'b1;
          cur_nxt = head.item;
          if (head.item.op == wfm_pkg::OP_LOAD) begin
            // A load abandons any name in progress.
            pos_nxt  = '0;
            ext_nxt  = 1'b0;
            skip_nxt = 1'b0;
            dec_nxt  = 1'b0;
            dval_nxt = 1'b0;
            if (closed_r) begin
              len_nxt    = '0;
              ovf_nxt    = 1'b0;
              closed_nxt = 1'b0;
            end
            if (head.item.term) begin
              closed_nxt = 1'b1;
            end else if (len_eff < LW'(wfm_pkg::PATTERN_DEPTH)) begin
              we      = 1'b1;
              len_nxt = len_eff + LW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (dec_r) begin
            finish = 1'b1;
          end else if (skip_r) begin
            if (head.item.dot) begin
              skip_nxt = 1'b0;
              finish   = 1'b1;
            end else if (head.item.term) begin
              skip_nxt  = 1'b0;
              state_nxt = ST_CMP;
            end else begin
              finish = 1'b1;
            end
          end else begin
            state_nxt = ST_CMP;
          end
        end
      end

      ST_CMP: begin
        priority if (pc == wfm_pkg::CH_NUL) begin
          dec_nxt  = 1'b1;
          dval_nxt = cur_r.term;
          finish   = 1'b1;
        end else if (pc == wfm_pkg::CH_STAR) begin
          if (ext_r) begin
            dec_nxt  = 1'b1;
            dval_nxt = 1'b1;
            finish   = 1'b1;
          end else begin
            pos_nxt   = pos_r + LW'(1);
            state_nxt = ST_SCAN;
          end
        end else if (pc == wfm_pkg::CH_QUEST) begin
          if (cur_r.dot || cur_r.term) begin
            dec_nxt  = 1'b1;
            dval_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r + LW'(1);
          end
          finish = 1'b1;
        end else if (pc == wfm_pkg::CH_DOT) begin
          if (!cur_r.dot) begin
            dec_nxt  = 1'b1;
            dval_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r + LW'(1);
            ext_nxt = 1'b1;
          end
          finish = 1'b1;
        end else begin
          if (wfm_pkg::upcase(cur_r.ch) != wfm_pkg::upcase(pc)) begin
            dec_nxt  = 1'b1;
            dval_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r + LW'(1);
          end
          finish = 1'b1;
        end
      end

      ST_SCAN: begin
        // rdata holds the pattern byte at pos_r.
        if (in_range && rdata != wfm_pkg::CH_DOT) begin
          pos_nxt = pos_r + LW'(1);
        end else begin
          if (in_range) begin
            pos_nxt = pos_r + LW'(1);
          end
          ext_nxt = 1'b1;
          if (cur_r.dot) begin
            finish = 1'b1;
          end else if (cur_r.term) begin
            state_nxt = ST_CMP;
          end else begin
            skip_nxt = 1'b1;
            finish   = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = ST_IDLE;
      if (c.term) begin
        valid_nxt = 1'b1;
        match_nxt = dec_nxt && dval_nxt && !ovf_r;
        povf_nxt  = ovf_r;
        pos_nxt   = '0;
        ext_nxt   = 1'b0;
        skip_nxt  = 1'b0;
        dec_nxt   = 1'b0;
        dval_nxt  = 1'b0;
      end
    end

    raddr = pos_nxt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      len_r     <= '0;
      pos_r     <= '0;
      ext_r     <= 1'b0;
      skip_r    <= 1'b0;
      dec_r     <= 1'b0;
      dval_r    <= 1'b0;
      ovf_r     <= 1'b0;
      closed_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      ext_r     <= ext_nxt;
      skip_r    <= skip_nxt;
      dec_r     <= dec_nxt;
      dval_r    <= dval_nxt;
      ovf_r     <= ovf_nxt;
      closed_r  <= closed_nxt;
      out_valid <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r                <= cur_nxt;
    out_match            <= match_nxt;
    out_pattern_overflow <= povf_nxt;
  end

endmodule
`default_nettype wire

### tb/wildcard_filename_matcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_filename_matcher_test
// Self-checking testbench for the DOS-style wildcard file name matcher.
// A scripted table of pattern and name bytes opens the run and a full-store
// and overflow sequence follows. After that come random patterns, each with
// a few names, mostly derived from the pattern so that matches occur. Every
// accepted transfer goes through a cycle-free model of the matcher, and each
// result strobe is compared with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module wildcard_filename_matcher_test;
  import wfm_pkg::*;

  // One predicted result of a completed file name.
  typedef struct packed {
    logic match;
    logic overflow;
  } name_verdict_t;

  // One row of the scripted opening. Only rows with a verdict that can be
  // read off directly carry it; the model decides all other rows.
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       typed;
    logic       want_match;
    logic       want_overflow;
  } stim_row_t;

  localparam int SCRIPT_ROWS  = 25;
  localparam int RANDOM_ITEMS = 310;
  // Covers a full-length star walk plus the two-entry queue in front of it.
  localparam int DRAIN_CYCLES = 600;

  logic clk                  = 1'b0;
  logic rst_n                = 1'b0;
  logic start                = 1'b0;
  logic in_operation         = OP_LOAD;
  logic [7:0] in_char_code   = CH_NUL;
  logic busy;
  logic out_valid;
  logic out_match;
  logic out_pattern_overflow;

  wildcard_filename_matcher dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_char_code         (in_char_code),
    .out_valid            (out_valid),
    .out_match            (out_match),
    .out_pattern_overflow (out_pattern_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Matcher model. It mirrors the block's architectural state: the stored
  // pattern, the scan position within it, name versus extension mode, the
  // skip-to-dot flag of a name-mode star, and the early verdict of the name
  // in progress.
  // --------------------------------------------------------------------------
  logic [7:0]  pat_mem [PATTERN_DEPTH];
  int unsigned pat_len       = 0;
  int unsigned pat_pos       = 0;
  bit          ext_mode      = 1'b0;
  bit          skip_dot      = 1'b0;
  bit          verdict_known = 1'b0;
  bit          verdict       = 1'b0;
  bit          store_ovf     = 1'b0;
  bit          pat_done      = 1'b0;

  name_verdict_t pending_verdicts [$];
  int            mismatches = 0;
  int            items_sent = 0;
  bit            idle_on    = 1'b1;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    // Only a-z fold; bytes around the letter range must stay as they are.
    return (c inside {[8'h61:8'h7A]}) ? (c & 8'hDF) : c;
  endfunction

  function automatic void restart_scan();
    pat_pos       = 0;
    ext_mode      = 1'b0;
    skip_dot      = 1'b0;
    verdict_known = 1'b0;
    verdict       = 1'b0;
  endfunction

  function automatic void settle(input bit v);
    verdict_known = 1'b1;
    verdict       = v;
  endfunction

  // Advances the scan by one name byte. A terminator may need a second pass,
  // after a star has been resolved, to see what the pattern holds next.
  function automatic void scan_name_byte(input logic [7:0] c);
    logic [7:0] pc;
    bit again;
    again = 1'b1;
    while (again && !verdict_known) begin
      again = 1'b0;
      if (skip_dot) begin
        if (c == CH_NUL) begin
          skip_dot = 1'b0;
          again    = 1'b1;
        end else if (c == CH_DOT) begin
          skip_dot = 1'b0;
        end
      end else begin
        pc = (pat_pos < pat_len) ? pat_mem[pat_pos] : CH_NUL;
        case (pc)
          CH_NUL: begin
            settle(c == CH_NUL);
          end
          CH_STAR: begin
            if (ext_mode) begin
              settle(1'b1);
            end else begin
              // Step past the star and past the next pattern dot, if any.
              pat_pos++;
              while (pat_pos < pat_len && pat_mem[pat_pos] != CH_DOT) pat_pos++;
              if (pat_pos < pat_len) pat_pos++;
              ext_mode = 1'b1;
              if (c == CH_NUL) again = 1'b1;
              else if (c != CH_DOT) skip_dot = 1'b1;
            end
          end
          CH_QUEST: begin
            if (c == CH_DOT || c == CH_NUL) settle(1'b0);
            else pat_pos++;
          end
          CH_DOT: begin
            if (c != CH_DOT) begin
              settle(1'b0);
            end else begin
              pat_pos++;
              ext_mode = 1'b1;
            end
          end
          default: begin
            if (fold_case(c) != fold_case(pc)) settle(1'b0);
            else pat_pos++;
          end
        endcase
      end
    end
  endfunction

  // Applies one accepted transfer; returns 1 when it completes a name.
  function automatic bit step_matcher(input logic op, input logic [7:0] c,
                                      output name_verdict_t v);
    v = '0;
    if (op == OP_LOAD) begin
      // The first load after a closed pattern starts a fresh one.
      if (pat_done) begin
        pat_len   = 0;
        store_ovf = 1'b0;
        pat_done  = 1'b0;
      end
      restart_scan();
      if (c == CH_NUL) begin
        pat_done = 1'b1;
      end else if (pat_len < PATTERN_DEPTH) begin
        pat_mem[pat_len] = c;
        pat_len++;
      end else begin
        store_ovf = 1'b1;
      end
      return 1'b0;
    end
    scan_name_byte(c);
    if (c != CH_NUL) return 1'b0;
    v.match    = verdict_known && verdict && !store_ovf;
    v.overflow = store_ovf;
    restart_scan();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers. Every call starts and ends right after a rising edge,
  // so each input gets at most one nonblocking update per time step.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Moves one byte across the command port, with an optional random gap
  // first. The model runs at the edge of the transfer; a row with a typed
  // verdict queues that verdict in place of the model's.
  task automatic send_byte(input logic op, input logic [7:0] c, input bit typed,
                           input name_verdict_t want);
    name_verdict_t got;
    if (idle_on && $urandom_range(0, 99) < 28) begin
      start        <= 1'b0;
      in_operation <= 1'($urandom_range(0, 1));
      in_char_code <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_char_code <= c;
    do @(posedge clk); while (busy);
    items_sent++;
    if (step_matcher(op, c, got)) pending_verdicts.push_back(typed ? want : got);
  endtask

  // Holds the sender off until every outstanding verdict has been checked.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // A name byte that is never a dot or a terminator, biased toward letters.
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      c = 8'($urandom_range(8'h61, 8'h7A)) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    end else begin
      c = 8'($urandom_range(1, 255));
      if (c == CH_DOT) c = "x";
    end
    return c;
  endfunction

  function automatic logic [7:0] pattern_char();
    case ($urandom_range(0, 9))
      0, 1:    return CH_STAR;
      2, 3:    return CH_QUEST;
      4:       return CH_DOT;
      5:       return "a";
      6:       return "B";
      7:       return "z";
      8:       return 8'h40;   // just below 'A', must not fold
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Scripted opening. It covers an empty pattern right after reset, a
  // mismatch against the empty pattern, case folding, '?' meeting a letter,
  // a dot switching to extension mode, an extension star matching at once,
  // a new pattern replacing a closed one, names checked against a pattern
  // that is still open, a name-mode star skipping to the dot, a load
  // abandoning a name in progress, and a star meeting the end of the name.
  // --------------------------------------------------------------------------
  stim_row_t script_rows [SCRIPT_ROWS] = '{
    '{OP_NAME, CH_NUL,   1'b1, 1'b1, 1'b0},  // empty pattern, empty name
    '{OP_NAME, "a",      1'b0, 1'b0, 1'b0},
    '{OP_NAME, CH_NUL,   1'b1, 1'b0, 1'b0},  // empty pattern, name "a"
    '{OP_LOAD, "A",      1'b0, 1'b0, 1'b0},
    '{OP_LOAD, CH_QUEST, 1'b0, 1'b0, 1'b0},
    '{OP_LOAD, CH_DOT,   1'b0, 1'b0, 1'b0},
    '{OP_LOAD, CH_STAR,  1'b0, 1'b0, 1'b0},
    '{OP_LOAD, CH_NUL,   1'b0, 1'b0, 1'b0},
    '{OP_NAME, "a",      1'b0, 1'b0, 1'b0},
    '{OP_NAME, "z",      1'b0, 1'b0, 1'b0},
    '{OP_NAME, CH_DOT,   1'b0, 1'b0, 1'b0},
    '{OP_NAME, 8'hFF,    1'b0, 1'b0, 1'b0},
    '{OP_NAME, CH_NUL,   1'b0, 1'b0, 1'b0},
    '{OP_NAME, CH_DOT,   1'b0, 1'b0, 1'b0},
    '{OP_NAME, CH_NUL,   1'b0, 1'b0, 1'b0},
    '{OP_LOAD, CH_STAR,  1'b0, 1'b0, 1'b0},
    '{OP_LOAD, CH_DOT,   1'b0, 1'b0, 1'b0},
    '{OP_LOAD, "Z",      1'b0, 1'b0, 1'b0},
    '{OP_NAME, "q",      1'b0, 1'b0, 1'b0},
    '{OP_NAME, CH_DOT,   1'b0, 1'b0, 1'b0},
    '{OP_NAME, "z",      1'b0, 1'b0, 1'b0},
    '{OP_NAME, CH_NUL,   1'b0, 1'b0, 1'b0},
    '{OP_NAME, "x",      1'b0, 1'b0, 1'b0},
    '{OP_LOAD, CH_NUL,   1'b0, 1'b0, 1'b0},
    '{OP_NAME, CH_NUL,   1'b0, 1'b0, 1'b0}
  };

  initial begin : stimulus
    name_verdict_t none;
    name_verdict_t ovf_only;
    logic [7:0]    pat_q [$];
    logic [7:0]    name_q [$];
    logic [7:0]    c;
    int            base;
    int            phase_no;
    int            len;
    int            kind;

    none     = '0;
    ovf_only = '{match: 1'b0, overflow: 1'b1};

    // Synchronous reset, held low from time zero.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_rows[i]) begin
      send_byte(script_rows[i].op, script_rows[i].ch, script_rows[i].typed,
                '{match: script_rows[i].want_match,
                  overflow: script_rows[i].want_overflow});
    end

    // Fill the store exactly: a leading star followed by bytes without a
    // dot, so a name-mode star walks the whole store. One more byte then
    // overflows it, and every name after that must report overflow with no
    // match, before and after the pattern is closed.
    send_byte(OP_LOAD, CH_STAR, 1'b0, none);
    repeat (PATTERN_DEPTH - 1) send_byte(OP_LOAD, name_char(), 1'b0, none);
    send_byte(OP_NAME, "a", 1'b0, none);
    send_byte(OP_NAME, "b", 1'b0, none);
    send_byte(OP_NAME, CH_NUL, 1'b0, none);
    send_byte(OP_LOAD, "k", 1'b0, none);
    send_byte(OP_NAME, "a", 1'b0, none);
    send_byte(OP_NAME, CH_NUL, 1'b1, ovf_only);
    send_byte(OP_LOAD, CH_NUL, 1'b0, none);
    send_byte(OP_NAME, CH_NUL, 1'b1, ovf_only);

    // Random phases: mostly a new pattern (usually closed), then a few names.
    // Most names are built from the pattern itself so that they get deep
    // into the scan; the rest are mutated, loose or plain noise, and now
    // and then a load cuts into a name.
    base     = items_sent;
    phase_no = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      phase_no++;
      // A stretch of phases runs back to back with no gaps at all.
      idle_on = !(phase_no >= 8 && phase_no < 14);
      if (phase_no % 23 == 5) drain_results();

      if (phase_no == 1 || $urandom_range(0, 9) < 8) begin
        pat_q.delete();
        len = $urandom_range(0, 8);
        repeat (len) pat_q.push_back(pattern_char());
        foreach (pat_q[i]) send_byte(OP_LOAD, pat_q[i], 1'b0, none);
        if ($urandom_range(0, 9) != 0) send_byte(OP_LOAD, CH_NUL, 1'b0, none);
      end

      repeat ($urandom_range(1, 4)) begin
        name_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          foreach (pat_q[i]) begin
            case (pat_q[i])
              CH_STAR:  repeat ($urandom_range(0, 3)) name_q.push_back(name_char());
              CH_QUEST: name_q.push_back(name_char());
              CH_DOT:   name_q.push_back(CH_DOT);
              default: begin
                c = pat_q[i];
                if (fold_case(c) inside {[8'h41:8'h5A]} && $urandom_range(0, 1)) c ^= 8'h20;
                name_q.push_back(c);
              end
            endcase
          end
          if (name_q.size() != 0 && $urandom_range(0, 3) == 0)
            name_q[$urandom_range(0, name_q.size() - 1)] = 8'($urandom_range(1, 255));
        end else if (kind < 90) begin
          repeat ($urandom_range(0, 6)) name_q.push_back(pattern_char());
        end else begin
          repeat ($urandom_range(0, 6)) name_q.push_back(8'($urandom_range(1, 255)));
        end

        foreach (name_q[i]) begin
          if ($urandom_range(0, 99) < 3)
            send_byte(OP_LOAD, 8'($urandom_range(0, 255)), 1'b0, none);
          send_byte(OP_NAME, name_q[i], 1'b0, none);
        end
        send_byte(OP_NAME, CH_NUL, 1'b0, none);
      end
    end

    // Let everything outstanding arrive, then watch for stray strobes.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result check. A strobe is a transfer by itself, since the receiver can
  // never stall, and it is compared with the oldest predicted verdict.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    name_verdict_t oldest;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result match=%0b overflow=%0b",
                                  out_match, out_pattern_overflow));
      end else begin
        oldest = pending_verdicts.pop_front();
        if (out_match !== oldest.match)
          report_mismatch($sformatf("match got %0b, expected %0b",
                                    out_match, oldest.match));
        if (out_pattern_overflow !== oldest.overflow)
          report_mismatch($sformatf("pattern_overflow got %0b, expected %0b",
                                    out_pattern_overflow, oldest.overflow));
      end
    end
  end

  // The slowest correct run stays far below this bound, even with every
  // gap at its longest and the full-store star walk included.
  initial begin : watchdog
    #(400_000 * 12);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/wfm_pkg.sv
hw/rtl/wfm_ram.sv
hw/rtl/wfm_front.sv
hw/rtl/wfm_back.sv
hw/rtl/wildcard_filename_matcher.sv
tb/wildcard_filename_matcher_test.sv
